[sv/ipds_pkg.sv]
// Shared types and constants for the image pair difference statistics block.
// Field widths of the result word and the result record carried down the pipe.
// No dependencies.
`default_nettype none

package ipds_pkg;

  localparam int NCH    = 3;
  localparam int TOL_W  = 14;
  localparam int IN_W   = 16;
  localparam int CNT_W  = 26;
  localparam int SUM_W  = 42;
  localparam int SQS_W  = 58;
  localparam int PIX_W  = 25;
  localparam int PROD_W = SUM_W + TOL_W;

  localparam logic [TOL_W-1:0] SCALE_10K = TOL_W'(10000);

  typedef struct packed {
    logic             cnt_nz;
    logic [CNT_W-1:0] big;
    logic [CNT_W-1:0] small_cnt;
    logic [SUM_W-1:0] sum_a;
    logic [SUM_W-1:0] sum_b;
    logic [SQS_W-1:0] sq_sum;
    logic [PIX_W-1:0] pix;
  } res_t;

endpackage

`default_nettype wire

[sv/image_pair_difference_statistics.sv]
// Throughput: one pixel word per cycle; the pipe stalls only while a finished
// result sits in the product stage and the output register is still occupied.
// Reset (synchronous, active low) clears valids, accumulators and tolerance.
// Stages: input reg, channel diff/square, accumulate, |diff|/min, products, output.
// Depends on ipds_pkg.
`default_nettype none

module image_pair_difference_statistics #(
  parameter int MAX_PIXELS  = 16777216,
  parameter int SAMPLE_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [ipds_pkg::TOL_W-1:0]   cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [ipds_pkg::IN_W-1:0]    in_first_red,
  input  wire  [ipds_pkg::IN_W-1:0]    in_first_green,
  input  wire  [ipds_pkg::IN_W-1:0]    in_first_blue,
  input  wire  [ipds_pkg::IN_W-1:0]    in_second_red,
  input  wire  [ipds_pkg::IN_W-1:0]    in_second_green,
  input  wire  [ipds_pkg::IN_W-1:0]    in_second_blue,
  input  wire                          in_final_pixel,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_images_differ,
  output logic [ipds_pkg::CNT_W-1:0]   out_big_count,
  output logic [ipds_pkg::CNT_W-1:0]   out_small_count,
  output logic [ipds_pkg::SUM_W-1:0]   out_first_sum,
  output logic [ipds_pkg::SUM_W-1:0]   out_second_sum,
  output logic [ipds_pkg::SQS_W-1:0]   out_squared_error_sum,
  output logic [ipds_pkg::PIX_W-1:0]   out_pixels_seen
);

  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int ERR_W = SAMPLE_BITS + 8;
  localparam int NCH   = ipds_pkg::NCH;

  logic [ipds_pkg::TOL_W-1:0] tol_r;

  logic                   en;
  logic [SAMPLE_BITS-1:0] in_a [NCH];
  logic [SAMPLE_BITS-1:0] in_b [NCH];

  logic                   s1_vld_r, s1_last_r;
  logic [SAMPLE_BITS-1:0] s1_a_r [NCH];
  logic [SAMPLE_BITS-1:0] s1_b_r [NCH];

  logic [SAMPLE_BITS-1:0] s2_a_nxt  [NCH];
  logic [SAMPLE_BITS-1:0] s2_b_nxt  [NCH];
  logic [SQ_W-1:0]        s2_sq_nxt [NCH];
  logic [NCH-1:0]         s2_sm_nxt, s2_lg_nxt;

  logic                   s2_vld_r, s2_last_r;
  logic [SAMPLE_BITS-1:0] s2_a_r  [NCH];
  logic [SAMPLE_BITS-1:0] s2_b_r  [NCH];
  logic [SQ_W-1:0]        s2_sq_r [NCH];
  logic [NCH-1:0]         s2_sm_r, s2_lg_r;

  logic [ipds_pkg::SUM_W-1:0] acc_a_r, acc_b_r, acc_a_nxt, acc_b_nxt;
  logic [ipds_pkg::SQS_W-1:0] acc_sq_r, acc_sq_nxt;
  logic [ipds_pkg::CNT_W-1:0] cnt_lg_r, cnt_sm_r, cnt_lg_nxt, cnt_sm_nxt;
  logic [ipds_pkg::PIX_W-1:0] pix_r, pix_nxt;
  logic                       last3;

  logic                 r3_vld_r;
  ipds_pkg::res_t       r3_r, r3_nxt;

  logic                       r4_vld_r;
  ipds_pkg::res_t             r4_r;
  logic [ipds_pkg::SUM_W-1:0] r4_d_r, r4_m_r, r4_d_nxt, r4_m_nxt;

  logic                        r5_vld_r;
  ipds_pkg::res_t              r5_r;
  logic [ipds_pkg::PROD_W-1:0] r5_p1_r, r5_p2_r;

  logic           out_vld_r;
  ipds_pkg::res_t out_r;
  logic           out_differ_r, differ_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  // stall only when a result in the product stage cannot move to the output
  assign en       = !(r5_vld_r && out_vld_r && !out_ready);
  assign in_ready = en;

  assign in_a[0] = in_first_red[SAMPLE_BITS-1:0];
  assign in_a[1] = in_first_green[SAMPLE_BITS-1:0];
  assign in_a[2] = in_first_blue[SAMPLE_BITS-1:0];
  assign in_b[0] = in_second_red[SAMPLE_BITS-1:0];
  assign in_b[1] = in_second_green[SAMPLE_BITS-1:0];
  assign in_b[2] = in_second_blue[SAMPLE_BITS-1:0];

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_last_r <= in_final_pixel;
      s1_a_r    <= in_a;
      s1_b_r    <= in_b;
    end
  end

  // stage 2: per-channel difference, square and relative error flags
  always_comb begin
    logic [SAMPLE_BITS-1:0] dif;
    dif = '0;
    for (int c = 0; c < NCH; c++) begin
      dif = (s1_a_r[c] > s1_b_r[c]) ? (s1_a_r[c] - s1_b_r[c]) : (s1_b_r[c] - s1_a_r[c]);
      s2_a_nxt[c]  = s1_a_r[c];
      s2_b_nxt[c]  = s1_b_r[c];
      s2_sq_nxt[c] = SQ_W'(dif) * SQ_W'(dif);
      s2_sm_nxt[c] = (ERR_W'(dif) * ERR_W'(200)) > ERR_W'(s1_a_r[c]);
      s2_lg_nxt[c] = (ERR_W'(dif) * ERR_W'(20)) > ERR_W'(s1_a_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_last_r <= s1_last_r;
      s2_a_r    <= s2_a_nxt;
      s2_b_r    <= s2_b_nxt;
      s2_sq_r   <= s2_sq_nxt;
      s2_sm_r   <= s2_sm_nxt;
      s2_lg_r   <= s2_lg_nxt;
    end
  end

  // stage 3: accumulate; snapshot and clear on the last pixel or when MAX_PIXELS is reached
  always_comb begin
    acc_a_nxt  = acc_a_r;
    acc_b_nxt  = acc_b_r;
    acc_sq_nxt = acc_sq_r;
    cnt_sm_nxt = cnt_sm_r;
    cnt_lg_nxt = cnt_lg_r;
    for (int c = 0; c < NCH; c++) begin
      acc_a_nxt  = acc_a_nxt + ipds_pkg::SUM_W'(s2_a_r[c]);
      acc_b_nxt  = acc_b_nxt + ipds_pkg::SUM_W'(s2_b_r[c]);
      acc_sq_nxt = acc_sq_nxt + ipds_pkg::SQS_W'(s2_sq_r[c]);
      cnt_sm_nxt = cnt_sm_nxt + ipds_pkg::CNT_W'(s2_sm_r[c]);
      cnt_lg_nxt = cnt_lg_nxt + ipds_pkg::CNT_W'(s2_lg_r[c]);
    end
    pix_nxt = pix_r + ipds_pkg::PIX_W'(1);
    last3   = s2_last_r || (pix_nxt >= ipds_pkg::PIX_W'(MAX_PIXELS));

    r3_nxt.cnt_nz    = (cnt_lg_nxt != '0) || (cnt_sm_nxt != '0);
    r3_nxt.big       = cnt_lg_nxt;
    r3_nxt.small_cnt = cnt_sm_nxt;
    r3_nxt.sum_a     = acc_a_nxt;
    r3_nxt.sum_b     = acc_b_nxt;
    r3_nxt.sq_sum    = acc_sq_nxt;
    r3_nxt.pix       = pix_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_a_r  <= '0;
      acc_b_r  <= '0;
      acc_sq_r <= '0;
      cnt_sm_r <= '0;
      cnt_lg_r <= '0;
      pix_r    <= '0;
      r3_vld_r <= 1'b0;
    end else if (en) begin
      r3_vld_r <= s2_vld_r && last3;
      if (s2_vld_r) begin
        if (last3) begin
          acc_a_r  <= '0;
          acc_b_r  <= '0;
          acc_sq_r <= '0;
          cnt_sm_r <= '0;
          cnt_lg_r <= '0;
          pix_r    <= '0;
        end else begin
          acc_a_r  <= acc_a_nxt;
          acc_b_r  <= acc_b_nxt;
          acc_sq_r <= acc_sq_nxt;
          cnt_sm_r <= cnt_sm_nxt;
          cnt_lg_r <= cnt_lg_nxt;
          pix_r    <= pix_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r3_r <= r3_nxt;
    end
  end

  // stage 4: absolute difference and minimum of the sums
  always_comb begin
    if (r3_r.sum_a > r3_r.sum_b) begin
      r4_d_nxt = r3_r.sum_a - r3_r.sum_b;
      r4_m_nxt = r3_r.sum_b;
    end else begin
      r4_d_nxt = r3_r.sum_b - r3_r.sum_a;
      r4_m_nxt = r3_r.sum_a;
    end
  end

  // stage 5: scaled difference and tolerance product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r4_vld_r <= 1'b0;
      r5_vld_r <= 1'b0;
    end else if (en) begin
      r4_vld_r <= r3_vld_r;
      r5_vld_r <= r4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r4_r    <= r3_r;
      r4_d_r  <= r4_d_nxt;
      r4_m_r  <= r4_m_nxt;
      r5_r    <= r4_r;
      r5_p1_r <= ipds_pkg::PROD_W'(r4_d_r) * ipds_pkg::PROD_W'(ipds_pkg::SCALE_10K);
      r5_p2_r <= ipds_pkg::PROD_W'(r4_m_r) * ipds_pkg::PROD_W'(tol_r);
    end
  end

  // output register
  assign differ_nxt = (tol_r == '0) ? r5_r.cnt_nz : (r5_p1_r > r5_p2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en && r5_vld_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && r5_vld_r) begin
      out_r        <= r5_r;
      out_differ_r <= differ_nxt;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_images_differ     = out_differ_r;
  assign out_big_count         = out_r.big;
  assign out_small_count       = out_r.small_cnt;
  assign out_first_sum         = out_r.sum_a;
  assign out_second_sum        = out_r.sum_b;
  assign out_squared_error_sum = out_r.sq_sum;
  assign out_pixels_seen       = out_r.pix;

`ifndef SYNTHESIS
  a_pix_range: assert property (@(posedge clk) disable iff (!rst_n)
    pix_r < ipds_pkg::PIX_W'(MAX_PIXELS))
    else $error("pixel counter out of range");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s2_vld_r && last3) |=> (pix_r == '0 && acc_sq_r == '0 && cnt_sm_r == '0))
    else $error("accumulators not cleared after last pixel");

  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.small_cnt >= out_r.big && out_r.pix != '0))
    else $error("inconsistent result counts");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (r5_vld_r && out_vld_r))
    else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire
